// ===== design/btt_pkg.sv =====
package btt_pkg;

    // Fixed field widths.
    localparam int LABEL_W   = 5;
    localparam int COMMAND_W = 2;
    localparam int ORDER_W   = 2;
    localparam int PHASE_W   = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register map: word index taken from paddr[2].
    localparam logic REG_ROOT_LABEL = 1'b0;

    // Item commands.
    typedef enum logic [COMMAND_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_WALK  = 2'd2
    } command_t;

    // Traversal orders. Each order emits a node when its stack entry
    // reaches the visit phase with the same code.
    typedef enum logic [ORDER_W-1:0] {
        ORDER_PRE  = 2'd0,
        ORDER_IN   = 2'd1,
        ORDER_POST = 2'd2
    } walk_order_t;

    // Visit phase of a stack entry.
    localparam logic [PHASE_W-1:0] PHASE_ENTER = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_MID   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_EXIT  = 2'd2;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [LABEL_W-1:0] label;
    } stack_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_STEP,
        ST_POP,
        ST_FINISH
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic latch_order;
        logic start;
        logic emit;
        logic advance;
        logic push;
        logic pop;
        logic load_top;
        logic set_err;
        logic send_last;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic root_ok;
        logic emit_req;
        logic count_full;
        logic held_valid;
        logic out_free;
        logic phase_exit;
        logic kid_ok;
        logic depth_full;
        logic depth_one;
        logic err;
    } ctl_status_t;

endpackage

// ===== design/binary_tree_traversal_core.sv =====
// Binary tree traversal core.
//
// Items arrive on the item channel (item_valid, item_stall) and carry a
// command: clear the node table, load one node's left and right children,
// or walk the tree from the root_label register in pre-, in- or post-order.
// Each label that a walk visits leaves on the result channel (result_valid,
// result_stall) as one item; the final item of a walk has last_of_walk set,
// and walk_error marks a walk cut short by more than NODE_COUNT visits or
// stack entries. A walk cut before any visit gives one item with label 0.
// The root_label register is written through the APB port at address 0.
//
// Clear and load finish in the cycle they are accepted, so the next item is
// taken in the cycle after. During a walk the controller handles one phase of
// the top stack entry per cycle (enter, after left, after right) while the
// output is not stalled; a pop adds ST_POP for the registered stack read.
// The first result of a walk is presented in the cycle after its second label
// is emitted, since each label waits until it is known whether it is the last.
// item_stall stays high while a walk runs. A stalled result holds in the
// output register, and the walk pauses at its next visit until it drains.
// Reset empties the node table, clears root_label to 0 and idles the block.
module binary_tree_traversal_core
    import btt_pkg::*;
#(
    parameter int NODE_COUNT = 26
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [COMMAND_W-1:0]  command,
    input  logic [LABEL_W-1:0]    node_label,
    input  logic [LABEL_W-1:0]    left_label,
    input  logic [LABEL_W-1:0]    right_label,
    input  logic [ORDER_W-1:0]    walk_order,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [LABEL_W-1:0]    visited_label,
    output logic                  last_of_walk,
    output logic                  walk_error
);

    logic [LABEL_W-1:0] root_label_reg;
    ctl_cmd_t           cmd;
    ctl_status_t        status;

    // Register writes complete in the access phase; the port never waits.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_label_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_ROOT_LABEL)
        begin
            root_label_reg <= pwdata[LABEL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ROOT_LABEL) ?
                    {{(APB_DATA_W - LABEL_W){1'b0}}, root_label_reg} : '0;

    btt_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .command    (command),
        .walk_order (walk_order),
        .status     (status),
        .cmd        (cmd)
    );

    btt_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .root_label    (root_label_reg),
        .node_label    (node_label),
        .left_label    (left_label),
        .right_label   (right_label),
        .walk_order    (walk_order),
        .result_stall  (result_stall),
        .result_valid  (result_valid),
        .visited_label (visited_label),
        .last_of_walk  (last_of_walk),
        .walk_error    (walk_error)
    );

    // The stack never grows past its capacity.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.push |-> !status.depth_full)
        else $error("stack push past capacity");

    // No label is emitted once the walk has used up its visits.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> !status.count_full)
        else $error("label emitted past the visit limit");

    // An error flag only rides on the final item of a walk.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (result_valid && walk_error) |-> last_of_walk)
        else $error("walk_error set on an item that is not the last");

    // Closing a walk puts its final item on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
                     cmd.send_last |=> (result_valid && last_of_walk))
        else $error("final item of a walk not presented");

endmodule

// ===== design/btt_ctrl.sv =====
module btt_ctrl
    import btt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [COMMAND_W-1:0] command,
    input  logic [ORDER_W-1:0]   walk_order,
    input  ctl_status_t          status,
    output ctl_cmd_t             cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    case (command)
                        CMD_CLEAR: cmd.clear = 1'b1;
                        CMD_LOAD:  cmd.load  = 1'b1;
                        CMD_WALK:
                        begin
                            if (walk_order == ORDER_PRE || walk_order == ORDER_IN ||
                                walk_order == ORDER_POST)
                            begin
                                cmd.latch_order = 1'b1;
                                state_next      = ST_START;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_START:
            begin
                if (status.root_ok)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_STEP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEP:
            begin
                if (status.emit_req && status.count_full)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if (status.emit_req && status.held_valid && !status.out_free)
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    cmd.emit = status.emit_req;
                    if (status.phase_exit)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = status.depth_one ? ST_FINISH : ST_POP;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        if (status.kid_ok)
                        begin
                            if (status.depth_full)
                            begin
                                cmd.set_err = 1'b1;
                                state_next  = ST_FINISH;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_POP:
            begin
                cmd.load_top = 1'b1;
                state_next   = ST_STEP;
            end
            ST_FINISH:
            begin
                if (status.held_valid || status.err)
                begin
                    if (status.out_free)
                    begin
                        cmd.send_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/btt_datapath.sv =====
module btt_datapath
    import btt_pkg::*;
#(
    parameter int NODE_COUNT = 26
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_cmd_t             cmd,
    output ctl_status_t          status,
    input  logic [LABEL_W-1:0]   root_label,
    input  logic [LABEL_W-1:0]   node_label,
    input  logic [LABEL_W-1:0]   left_label,
    input  logic [LABEL_W-1:0]   right_label,
    input  logic [ORDER_W-1:0]   walk_order,
    input  logic                 result_stall,
    output logic                 result_valid,
    output logic [LABEL_W-1:0]   visited_label,
    output logic                 last_of_walk,
    output logic                 walk_error
);

    localparam int CNT_W = $clog2(NODE_COUNT + 1);
    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam logic [LABEL_W-1:0] NODE_LIMIT = LABEL_W'(NODE_COUNT);
    localparam logic [CNT_W-1:0]   CNT_LIMIT  = CNT_W'(NODE_COUNT);
    localparam logic [CNT_W-1:0]   CNT_ONE    = CNT_W'(1);
    localparam logic [CNT_W-1:0]   CNT_TWO    = CNT_W'(2);

    // Node table. Child entries have no reset; the present bits guard them.
    logic [NODE_COUNT-1:0] present_reg;
    logic [LABEL_W-1:0]    left_mem [NODE_COUNT];
    logic [LABEL_W-1:0]    right_mem [NODE_COUNT];

    // Walk stack: the top entry lives in a register, the rest in memory.
    stack_entry_t stack_mem [NODE_COUNT];
    stack_entry_t stack_rd_reg;
    stack_entry_t top_reg;
    stack_entry_t top_next;
    logic [CNT_W-1:0] depth_reg;
    logic [CNT_W-1:0] count_reg;
    logic [ORDER_W-1:0] order_reg;
    logic err_reg;

    // One emitted label is held back until it is known whether it is the last.
    logic [LABEL_W-1:0] held_label_reg;
    logic               held_valid_reg;

    logic               result_valid_reg;
    logic [LABEL_W-1:0] visited_label_reg;
    logic               last_reg;
    logic               error_reg;

    logic               node_ok;
    logic [IDX_W-1:0]   node_idx;
    logic [IDX_W-1:0]   top_idx;
    logic [IDX_W-1:0]   next_idx;
    logic [LABEL_W-1:0] kid_reg;
    logic [PHASE_W-1:0] phase_after;
    logic [CNT_W-1:0]   push_addr;
    logic [CNT_W-1:0]   pop_addr;
    logic               out_free;

    assign node_ok   = node_label < NODE_LIMIT;
    assign node_idx  = node_label[IDX_W-1:0];
    assign top_idx   = top_reg.label[IDX_W-1:0];
    assign next_idx  = top_next.label[IDX_W-1:0];
    assign phase_after = (top_reg.phase == PHASE_ENTER) ? PHASE_MID : PHASE_EXIT;
    assign push_addr = depth_reg - CNT_ONE;
    assign pop_addr  = depth_reg - CNT_TWO;
    assign out_free  = !result_valid_reg || !result_stall;

    assign status.root_ok    = root_label < NODE_LIMIT;
    assign status.emit_req   = top_reg.phase == order_reg;
    assign status.count_full = count_reg == CNT_LIMIT;
    assign status.held_valid = held_valid_reg;
    assign status.out_free   = out_free;
    assign status.phase_exit = top_reg.phase == PHASE_EXIT;
    assign status.kid_ok     = present_reg[top_idx] && (kid_reg < NODE_LIMIT);
    assign status.depth_full = depth_reg == CNT_LIMIT;
    assign status.depth_one  = depth_reg == CNT_ONE;
    assign status.err        = err_reg;

    always_comb
    begin
        top_next = top_reg;
        if (cmd.start)
        begin
            top_next = '{phase: PHASE_ENTER, label: root_label};
        end
        else if (cmd.push)
        begin
            top_next = '{phase: PHASE_ENTER, label: kid_reg};
        end
        else if (cmd.advance)
        begin
            top_next.phase = phase_after;
        end
        else if (cmd.load_top)
        begin
            top_next = stack_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
        end
        else if (cmd.clear)
        begin
            present_reg <= '0;
        end
        else if (cmd.load && node_ok)
        begin
            present_reg[node_idx] <= 1'b1;
        end
    end

    // The first load of a label wins. The child that the next top entry
    // will visit is looked up from top_next into kid_reg, so it is ready in its step.
    always_ff @(posedge clk)
    begin
        if (cmd.load && node_ok && !present_reg[node_idx])
        begin
            left_mem[node_idx]  <= left_label;
            right_mem[node_idx] <= right_label;
        end
        if (top_next.phase == PHASE_ENTER)
        begin
            kid_reg <= left_mem[next_idx];
        end
        else
        begin
            kid_reg <= right_mem[next_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[push_addr[IDX_W-1:0]] <= '{phase: phase_after, label: top_reg.label};
        end
        if (cmd.pop)
        begin
            stack_rd_reg <= stack_mem[pop_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg        <= '0;
            depth_reg      <= '0;
            count_reg      <= '0;
            order_reg      <= '0;
            err_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg <= top_next;
            if (cmd.latch_order)
            begin
                order_reg <= walk_order;
            end
            if (cmd.start)
            begin
                depth_reg      <= CNT_ONE;
                count_reg      <= '0;
                err_reg        <= 1'b0;
                held_valid_reg <= 1'b0;
            end
            if (cmd.set_err)
            begin
                err_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                count_reg      <= count_reg + CNT_ONE;
                held_valid_reg <= 1'b1;
            end
            if (cmd.send_last)
            begin
                held_valid_reg <= 1'b0;
            end
            if (cmd.push)
            begin
                depth_reg <= depth_reg + CNT_ONE;
            end
            if (cmd.pop)
            begin
                depth_reg <= depth_reg - CNT_ONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            held_label_reg <= top_reg.label;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.send_last || (cmd.emit && held_valid_reg))
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.send_last)
        begin
            visited_label_reg <= held_valid_reg ? held_label_reg : '0;
            last_reg          <= 1'b1;
            error_reg         <= err_reg;
        end
        else if (cmd.emit && held_valid_reg)
        begin
            visited_label_reg <= held_label_reg;
            last_reg          <= 1'b0;
            error_reg         <= 1'b0;
        end
    end

    assign result_valid  = result_valid_reg;
    assign visited_label = visited_label_reg;
    assign last_of_walk  = last_reg;
    assign walk_error    = error_reg;

endmodule
